>>> rtl/core/acm_pkg.sv
// acm_pkg: shared types, constants and register indexes of the autorange current meter
// no dependencies; used by every module in rtl/core
package acm_pkg;

    // window length and derived widths
    localparam int WINDOW_DEPTH = 8;
    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W        = SUM_W + 7;

    // range stepping
    localparam int RANGE_W      = 2;
    localparam int NUM_RANGES   = 4;
    localparam logic [RANGE_W-1:0] RANGE_TOP = RANGE_W'(NUM_RANGES - 1);

    // thresholds in percent
    localparam int FULL_PERCENT = 100;
    localparam int HI_PERCENT   = 95;
    localparam int LO_PERCENT   = 5;

    // data paths
    localparam int GAIN_W   = 32;
    localparam int CUR_W    = 32;
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int GAIN_FRAC = 16;

    // register port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN0      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN1      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN2      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN3      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RANGE = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL     = CFG_IDX_W'(6);

    // reset values
    localparam logic [GAIN_W-1:0]   RESET_GAIN   = GAIN_W'(65536);
    localparam logic [SAMPLE_W-1:0] RESET_REFILL = SAMPLE_W'(15000);
    localparam logic [RANGE_W-1:0]  RESET_RANGE  = RANGE_W'(0);

    // window control shared by every cell
    typedef struct packed {
        logic shift;
        logic fill;
    } t_win_ctl;

    // per-item side information carried down the current pipeline
    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic               changed;
    } t_item_info;

endpackage

>>> rtl/core/acm_cell.sv
// acm_cell: one entry of the sample window, shifts from its neighbour or refills
// depends on acm_pkg
module acm_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  acm_pkg::t_win_ctl              i_ctl,
    input  logic [acm_pkg::SAMPLE_W-1:0]   i_fill_value,
    input  logic [acm_pkg::SAMPLE_W-1:0]   i_data,
    output logic [acm_pkg::SAMPLE_W-1:0]   o_data
);

    logic [acm_pkg::SAMPLE_W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= acm_pkg::RESET_REFILL;
        end else if (i_ctl.fill) begin
            r_entry <= i_fill_value;
        end else if (i_ctl.shift) begin
            r_entry <= i_data;
        end
    end

    assign o_data = r_entry;

endmodule

>>> rtl/core/acm_window.sv
// acm_window: chain of window cells plus the running sum of the window
// depends on acm_pkg and acm_cell
module acm_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  acm_pkg::t_win_ctl              i_ctl,
    input  logic [acm_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [acm_pkg::SAMPLE_W-1:0]   i_fill_value,
    output logic [acm_pkg::SUM_W-1:0]      o_sum,
    output logic [acm_pkg::SUM_W-1:0]      o_sum_next
);

    logic [acm_pkg::SAMPLE_W-1:0] w_data [acm_pkg::WINDOW_DEPTH];
    logic [acm_pkg::SUM_W-1:0]    r_sum;
    logic [acm_pkg::SUM_W-1:0]    n_sum;
    logic [acm_pkg::SUM_W-1:0]    w_fill_sum;

    // cell 0 holds the oldest sample, the newest enters at the top
    for (genvar g = 0; g < acm_pkg::WINDOW_DEPTH; g++) begin : g_cell
        if (g == acm_pkg::WINDOW_DEPTH - 1) begin : g_top
            acm_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_fill_value (i_fill_value),
                .i_data       (i_sample),
                .o_data       (w_data[g])
            );
        end else begin : g_mid
            acm_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_fill_value (i_fill_value),
                .i_data       (w_data[g+1]),
                .o_data       (w_data[g])
            );
        end
    end

    assign o_sum_next = r_sum - acm_pkg::SUM_W'(w_data[0]) + acm_pkg::SUM_W'(i_sample);
    assign w_fill_sum = acm_pkg::SUM_W'(i_fill_value)
                        * acm_pkg::SUM_W'(acm_pkg::WINDOW_DEPTH);

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.fill) begin
            n_sum = w_fill_sum;
        end else if (i_ctl.shift) begin
            n_sum = o_sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= acm_pkg::SUM_W'(acm_pkg::RESET_REFILL)
                     * acm_pkg::SUM_W'(acm_pkg::WINDOW_DEPTH);
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> rtl/core/acm_current.sv
// acm_current: elastic pipeline for gain multiply, offset add and saturation
// depends on acm_pkg
module acm_current (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic [acm_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic [acm_pkg::GAIN_W-1:0]          i_gain,
    input  acm_pkg::t_item_info                 i_info,
    input  logic signed [acm_pkg::CUR_W-1:0]    i_offset,
    output logic                                o_free,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [acm_pkg::CUR_W-1:0]    o_current,
    output acm_pkg::t_item_info                 o_info
);

    localparam int ACC_W = acm_pkg::CUR_W + 2;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    logic [acm_pkg::SAMPLE_W-1:0] r_sample1;
    logic [acm_pkg::GAIN_W-1:0]   r_gain1;
    acm_pkg::t_item_info          r_info1, r_info2, r_info3;
    logic [acm_pkg::CUR_W-1:0]    r_prod2;
    logic signed [acm_pkg::CUR_W-1:0] r_cur3;

    logic [acm_pkg::PROD_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]      w_acc;
    logic signed [acm_pkg::CUR_W-1:0] w_sat;

    // a stage moves when its successor is empty or moving
    assign en3    = !r_v3 || i_ready;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign o_free = en1;

    assign w_prod = acm_pkg::PROD_W'(r_sample1) * acm_pkg::PROD_W'(r_gain1);

    assign w_acc = $signed({2'b00, r_prod2})
                   + $signed({{2{i_offset[acm_pkg::CUR_W-1]}}, i_offset});

    always_comb begin
        if (w_acc > SAT_MAX) begin
            w_sat = SAT_MAX[acm_pkg::CUR_W-1:0];
        end else if (w_acc < SAT_MIN) begin
            w_sat = SAT_MIN[acm_pkg::CUR_W-1:0];
        end else begin
            w_sat = w_acc[acm_pkg::CUR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_load;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample1 <= i_sample;
            r_gain1   <= i_gain;
            r_info1   <= i_info;
        end
        if (en2 && r_v1) begin
            r_prod2 <= w_prod[acm_pkg::GAIN_FRAC +: acm_pkg::CUR_W];
            r_info2 <= r_info1;
        end
        if (en3 && r_v2) begin
            r_cur3  <= w_sat;
            r_info3 <= r_info2;
        end
    end

    assign o_valid   = r_v3;
    assign o_current = r_cur3;
    assign o_info    = r_info3;

endmodule

>>> rtl/core/autorange_current_meter_core.sv
// autorange_current_meter_core: top level of the autoranging current meter
// depends on acm_pkg, acm_window (with acm_cell) and acm_current
//
//  channel   direction  signals                                        accepted when
//  input     in         i_valid o_ready i_sample_volts i_ref_volts     i_valid & o_ready
//  output    out        o_valid i_ready o_current_value                o_valid & i_ready
//                       o_active_range o_range_changed
//  config    in         i_cfg_we i_cfg_idx i_cfg_data                  i_cfg_we
//
//  one item per cycle sustained while i_ready holds; the window update and range decision close
//  in the accept cycle, so each item sees the window and range that the previous one left
//  results are registered after gain select, after multiply and after offset and clamp
//  synchronous active-low reset loads register defaults and fills the window
//  a stall on the output backs up the pipeline; bubbles are squeezed out before
//  o_ready drops, so the input keeps flowing while any stage is empty
module autorange_current_meter_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input items
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [acm_pkg::SAMPLE_W-1:0]           i_sample_volts,
    input  logic [acm_pkg::SAMPLE_W-1:0]           i_ref_volts,
    // result items
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [acm_pkg::CUR_W-1:0]       o_current_value,
    output logic [acm_pkg::RANGE_W-1:0]            o_active_range,
    output logic                                   o_range_changed,
    // register writes
    input  logic                                   i_cfg_we,
    input  logic [acm_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [acm_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    // configuration registers
    logic [acm_pkg::GAIN_W-1:0]         r_gain [acm_pkg::NUM_RANGES];
    logic signed [acm_pkg::CUR_W-1:0]   r_offset;
    logic [acm_pkg::SAMPLE_W-1:0]       r_refill;

    // range state
    logic [acm_pkg::RANGE_W-1:0]        r_range;
    logic [acm_pkg::RANGE_W-1:0]        n_range;

    logic                               w_accept;
    logic                               w_init_wr;
    logic [acm_pkg::SUM_W-1:0]          w_sum;
    logic [acm_pkg::SUM_W-1:0]          w_sum_next;
    logic [acm_pkg::CMP_W-1:0]          w_scaled;
    logic [acm_pkg::CMP_W-1:0]          w_hi_lim;
    logic [acm_pkg::CMP_W-1:0]          w_lo_lim;
    logic [acm_pkg::RANGE_W-1:0]        w_range_after;
    logic                               w_changed;
    logic                               w_free;
    acm_pkg::t_win_ctl                  w_win_ctl;
    acm_pkg::t_item_info                w_info_in;
    acm_pkg::t_item_info                w_info_out;

    assign o_ready   = w_free;
    assign w_accept  = i_valid && w_free;
    assign w_init_wr = i_cfg_we && (i_cfg_idx == acm_pkg::CFG_INIT_RANGE);

    // register file; initial_range also reloads the range and refills the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < acm_pkg::NUM_RANGES; k++) begin
                r_gain[k] <= acm_pkg::RESET_GAIN;
            end
            r_offset <= '0;
            r_refill <= acm_pkg::RESET_REFILL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acm_pkg::CFG_GAIN0, acm_pkg::CFG_GAIN1,
                acm_pkg::CFG_GAIN2, acm_pkg::CFG_GAIN3: begin
                    r_gain[i_cfg_idx[acm_pkg::RANGE_W-1:0]] <= i_cfg_data[acm_pkg::GAIN_W-1:0];
                end
                acm_pkg::CFG_OFFSET: begin
                    r_offset <= $signed(i_cfg_data[acm_pkg::CUR_W-1:0]);
                end
                acm_pkg::CFG_REFILL: begin
                    r_refill <= i_cfg_data[acm_pkg::SAMPLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // window mean against 95% and 5% of the reference, done without a divider:
    // 100 * sum is compared with percent * depth * vref
    assign w_scaled = acm_pkg::CMP_W'(w_sum_next) * acm_pkg::CMP_W'(acm_pkg::FULL_PERCENT);
    assign w_hi_lim = acm_pkg::CMP_W'(i_ref_volts)
                      * acm_pkg::CMP_W'(acm_pkg::HI_PERCENT * acm_pkg::WINDOW_DEPTH);
    assign w_lo_lim = acm_pkg::CMP_W'(i_ref_volts)
                      * acm_pkg::CMP_W'(acm_pkg::LO_PERCENT * acm_pkg::WINDOW_DEPTH);

    // step down on a high mean, up on a low one, clamped at both ends
    always_comb begin
        w_range_after = r_range;
        w_changed     = 1'b0;
        if (w_scaled > w_hi_lim) begin
            if (r_range != '0) begin
                w_range_after = r_range - acm_pkg::RANGE_W'(1);
                w_changed     = 1'b1;
            end
        end else if (w_scaled < w_lo_lim) begin
            if (r_range != acm_pkg::RANGE_TOP) begin
                w_range_after = r_range + acm_pkg::RANGE_W'(1);
                w_changed     = 1'b1;
            end
        end
    end

    // a range step discards the new sample and refills the window
    assign w_win_ctl.shift = w_accept && !w_changed;
    assign w_win_ctl.fill  = (w_accept && w_changed) || w_init_wr;

    always_comb begin
        n_range = r_range;
        if (w_init_wr) begin
            n_range = i_cfg_data[acm_pkg::RANGE_W-1:0];
        end else if (w_accept) begin
            n_range = w_range_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= acm_pkg::RESET_RANGE;
        end else begin
            r_range <= n_range;
        end
    end

    acm_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_win_ctl),
        .i_sample     (i_sample_volts),
        .i_fill_value (r_refill),
        .o_sum        (w_sum),
        .o_sum_next   (w_sum_next)
    );

    // the current uses the range as it stands after this item's step
    assign w_info_in.range   = w_range_after;
    assign w_info_in.changed = w_changed;

    acm_current u_current (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_accept),
        .i_sample  (i_sample_volts),
        .i_gain    (r_gain[w_range_after]),
        .i_info    (w_info_in),
        .i_offset  (r_offset),
        .o_free    (w_free),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_current (o_current_value),
        .o_info    (w_info_out)
    );

    assign o_active_range  = w_info_out.range;
    assign o_range_changed = w_info_out.changed;

    // a range step leaves the window sum at depth times the refill level
    a_refill_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_changed) |=> (w_sum == $past(acm_pkg::SUM_W'(r_refill)
                                     * acm_pkg::SUM_W'(acm_pkg::WINDOW_DEPTH))))
        else $error("window sum not refilled after range step");

    // an item with no step leaves the range alone
    a_range_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_changed && !i_cfg_we) |=> $stable(r_range))
        else $error("range moved without a step");

    // an item flagged as a step really moves the range
    a_range_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_changed && !i_cfg_we) |=> (r_range != $past(r_range)))
        else $error("range step flagged but range unchanged");

endmodule

>>> sim/acm_checker.sv
`timescale 1ns / 100ps
// acm_checker: predicts each current reading of the autoranging meter and checks results
// depends on acm_pkg; watches the item, result and register ports beside the core
module acm_checker
    import acm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [SAMPLE_W-1:0]         i_sample,
    input  logic [SAMPLE_W-1:0]         i_ref,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [CUR_W-1:0]     i_current,
    input  logic [RANGE_W-1:0]          i_range,
    input  logic                        i_changed,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output int                          o_pending,
    output int                          o_errors
);

    localparam int     PCT_FULL = 100;
    localparam int     PCT_HIGH = 95;
    localparam int     PCT_LOW  = 5;
    localparam longint AMPS_MAX = 64'sd2147483647;
    localparam longint AMPS_MIN = -AMPS_MAX - 1;

    typedef struct packed {
        logic signed [CUR_W-1:0] amps;
        logic [RANGE_W-1:0]      range_idx;
        logic                    stepped;
    } t_reading;

    // mirrored meter state and registers
    logic [SAMPLE_W-1:0]     window [WINDOW_DEPTH];
    int unsigned             win_sum;
    logic [RANGE_W-1:0]      range_now;
    logic [GAIN_W-1:0]       gain [NUM_RANGES];
    logic signed [CUR_W-1:0] offset;
    logic [SAMPLE_W-1:0]     refill;

    t_reading readings_due [$];
    t_reading want;

    function automatic void refill_window();
        for (int i = 0; i < WINDOW_DEPTH; i++)
            window[i] = refill;
        win_sum = WINDOW_DEPTH * refill;
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN0, CFG_GAIN1, CFG_GAIN2, CFG_GAIN3: begin
                gain[idx[RANGE_W-1:0]] = data;
            end
            CFG_OFFSET: begin
                offset = data;
            end
            CFG_INIT_RANGE: begin
                range_now = data[RANGE_W-1:0];
                refill_window();
            end
            CFG_REFILL: begin
                refill = data[SAMPLE_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_reading take_reading(input logic [SAMPLE_W-1:0] sample,
                                              input logic [SAMPLE_W-1:0] vref);
        t_reading        res;
        longint unsigned scaled;
        longint unsigned hi_lim;
        longint unsigned lo_lim;
        longint          amps;
        logic            stepped;
        stepped = 1'b0;
        win_sum = win_sum - window[0] + sample;
        for (int i = 0; i < WINDOW_DEPTH - 1; i++)
            window[i] = window[i+1];
        window[WINDOW_DEPTH-1] = sample;

        // exact mean tests, both sides scaled to avoid division
        scaled = 64'(win_sum) * PCT_FULL;
        hi_lim = 64'(vref) * PCT_HIGH * WINDOW_DEPTH;
        lo_lim = 64'(vref) * PCT_LOW * WINDOW_DEPTH;
        if (scaled > hi_lim) begin
            if (range_now != '0) begin
                range_now = range_now - 1'b1;
                stepped   = 1'b1;
            end
        end else if (scaled < lo_lim) begin
            if (range_now != RANGE_TOP) begin
                range_now = range_now + 1'b1;
                stepped   = 1'b1;
            end
        end
        if (stepped)
            refill_window();

        amps = longint'((64'(sample) * 64'(gain[range_now])) >> 16) + longint'(offset);
        if (amps > AMPS_MAX)
            amps = AMPS_MAX;
        if (amps < AMPS_MIN)
            amps = AMPS_MIN;
        res.amps      = amps[CUR_W-1:0];
        res.range_idx = range_now;
        res.stepped   = stepped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_RANGES; r++)
                gain[r] = RESET_GAIN;
            offset    = '0;
            refill    = RESET_REFILL;
            range_now = RESET_RANGE;
            refill_window();
            readings_due.delete();
        end else begin
            if (i_cfg_we)
                write_register(i_cfg_idx, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    $error("result item with no expectation waiting");
                    o_errors++;
                end else begin
                    want = readings_due.pop_front();
                    if (i_current !== want.amps) begin
                        $error("current_value: expected %0d, got %0d",
                               $signed(want.amps), i_current);
                        o_errors++;
                    end
                    if (i_range !== want.range_idx) begin
                        $error("active_range: expected %0d, got %0d", want.range_idx, i_range);
                        o_errors++;
                    end
                    if (i_changed !== want.stepped) begin
                        $error("range_changed: expected %0d, got %0d", want.stepped, i_changed);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                readings_due.push_back(take_reading(i_sample, i_ref));
        end
        o_pending = readings_due.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench: drives sample items and register writes into the autoranging current meter
// depends on acm_pkg, autorange_current_meter_core and acm_checker
module testbench;
    import acm_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the pipeline
    localparam int STALL_LIMIT   = 5000;  // cycles without any transfer or register write before giving up
    localparam int TAIL_CYCLES   = 8;     // extra wait after the last result before the verdict
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 325;
    localparam int QUIET_PHASE   = 2;     // no idling on either side
    localparam int HOLD_PHASE    = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(7);  // unmapped index

    // shape of the samples within a burst
    typedef enum int {LEVEL_LOW, LEVEL_HIGH, LEVEL_MIXED} t_level;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_ready;
    logic [SAMPLE_W-1:0]     i_sample_volts = '0;
    logic [SAMPLE_W-1:0]     i_ref_volts    = '0;
    logic                    o_valid;
    logic                    i_ready        = 1'b0;
    logic signed [CUR_W-1:0] o_current_value;
    logic [RANGE_W-1:0]      o_active_range;
    logic                    o_range_changed;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data     = '0;

    int pending;
    int errors;
    int stall_cycles = 0;
    int hold_req     = 0;
    int hold_served  = 0;
    bit quiet        = 1'b0;

    always #5 i_clk = ~i_clk;

    autorange_current_meter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_volts  (i_sample_volts),
        .i_ref_volts     (i_ref_volts),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_current_value (o_current_value),
        .o_active_range  (o_active_range),
        .o_range_changed (o_range_changed),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    acm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_sample    (i_sample_volts),
        .i_ref       (i_ref_volts),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_current   (o_current_value),
        .i_range     (o_active_range),
        .i_changed   (o_range_changed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // result side: random back-pressure, or one long hold-off when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_req) begin
                hold_served++;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= quiet || ($urandom_range(99) >= 32);
            end
        end
    end

    // watchdog: any transfer or register write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // offer one item; valid stays up on return so back-to-back items need no gap
    task automatic send_item(input logic [SAMPLE_W-1:0] sample,
                             input logic [SAMPLE_W-1:0] vref);
        while (!quiet && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_volts <= sample;
        i_ref_volts    <= vref;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // register writes run back to back; only the last one drops the enable
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (last)
            i_cfg_we <= 1'b0;
    endtask

    // stop offering and wait until every reading has come back
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return RESET_GAIN;
            3, 4, 5: return $urandom_range(0, 32'h0004_0000);  // up to 4.0, mostly unsaturated
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_offset();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3, 4:    return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_refill();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_ref();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(1, 255));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // whole register set, then the initial range so the refill level is already in place
    task automatic configure_random(input int phase);
        cfg_write(CFG_GAIN0, pick_gain(), 1'b0);
        cfg_write(CFG_GAIN1, pick_gain(), 1'b0);
        cfg_write(CFG_GAIN2, pick_gain(), 1'b0);
        cfg_write(CFG_GAIN3, pick_gain(), 1'b0);
        cfg_write(CFG_OFFSET, pick_offset(), 1'b0);
        cfg_write(CFG_SPARE, $urandom, 1'b0);
        cfg_write(CFG_REFILL, {16'($urandom), pick_refill()}, 1'b0);
        cfg_write(CFG_INIT_RANGE, ($urandom & ~32'h3) | (phase % NUM_RANGES), 1'b1);
    endtask

    // bursts share one reference; low bursts push the range up, high bursts pull it down,
    // and a tenth of the samples are plain noise
    task automatic send_random(input int count);
        int                  left;
        int                  burst;
        t_level              level;
        logic [SAMPLE_W-1:0] vref;
        logic [SAMPLE_W-1:0] sample;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(4, 48);
            level = t_level'($urandom_range(2));
            vref  = pick_ref();
            for (int n = 0; n < burst && left > 0; n++) begin
                if ($urandom_range(9) == 0)
                    sample = SAMPLE_W'($urandom);
                else begin
                    case (level)
                        LEVEL_LOW:  sample = SAMPLE_W'($urandom_range(0, vref / 25));
                        LEVEL_HIGH: sample = SAMPLE_W'($urandom_range(vref, 16'hFFFF));
                        default:    sample = SAMPLE_W'($urandom_range(0, vref));
                    endcase
                end
                send_item(sample, vref);
                left--;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: mean exactly at the upper threshold, then floor and zero reference
        send_item(16'd9000, 16'd15000);
        send_item(16'hFFFF, 16'd0);
        send_item(16'd0, 16'hFFFF);
        settle();

        // two downward steps, the second with the mean just over the upper threshold
        cfg_write(CFG_INIT_RANGE, 32'd2, 1'b1);
        send_item(16'd15000, 16'd10000);
        send_item(16'd9000, 16'd14999);
        settle();

        // extreme gains, top offset, tiny refill: lower threshold exact, then just missed
        cfg_write(CFG_GAIN0, 32'hFFFF_FFFF, 1'b0);
        cfg_write(CFG_GAIN1, 32'h0000_0000, 1'b0);
        cfg_write(CFG_GAIN2, 32'h0001_0000, 1'b0);
        cfg_write(CFG_GAIN3, 32'h8000_0000, 1'b0);
        cfg_write(CFG_OFFSET, 32'h7FFF_FFFF, 1'b0);
        cfg_write(CFG_REFILL, 32'd100, 1'b0);
        cfg_write(CFG_INIT_RANGE, 32'd1, 1'b1);
        send_item(16'd100, 16'd2000);
        send_item(16'd100, 16'd2001);
        send_item(16'd0, 16'hFFFF);
        send_item(16'd0, 16'hFFFF);   // ceiling holds
        send_item(16'hFFFF, 16'hFFFF); // saturates high
        send_item(16'hFFFF, 16'd0);
        settle();

        // bottom offset, all-zero window: zero mean at zero reference leaves the range alone
        cfg_write(CFG_OFFSET, 32'h8000_0000, 1'b0);
        cfg_write(CFG_SPARE, 32'hA5A5_5A5A, 1'b0);
        cfg_write(CFG_REFILL, 32'd0, 1'b0);
        cfg_write(CFG_INIT_RANGE, 32'd2, 1'b1);
        send_item(16'd0, 16'd0);
        send_item(16'd1, 16'd0);
        send_item(16'hFFFF, 16'd0);
        send_item(16'hFFFF, 16'hFFFF);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            configure_random(p);
            quiet = (p == QUIET_PHASE);
            if (p == HOLD_PHASE)
                hold_req++;
            send_random(PHASE_ITEMS);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
